// ----- src/bta_pkg.sv -----
// Shared types, codes and constants for the bitmap tile assembler.
// No dependencies; bta_ctrl, bta_datapath and bitmap_tile_assembler import this package.
package bta_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int COUNT_W        = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] CMD_TILE  = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] ST_TILE_DONE = 2'd0;
   localparam logic [1:0] ST_COMPLETE  = 2'd1;
   localparam logic [1:0] ST_READ      = 2'd2;

   localparam logic [1:0] CSR_BITMAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BITMAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_MODE    = 2'd2;

   typedef struct packed {
      logic load;
      logic decode;
      logic addr;
      logic rd0;
      logic wr0;
      logic wr1;
      logic wrc;
      logic step;
      logic rdata;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd_code;
      logic       tile_open;
      logic       place_mono;
      logic       place_colour;
      logic       last_byte;
      logic       rsp_full;
   } dp_status_type;

   // leading-ones mask for a partial source byte of n bits, n = 1..8
   function automatic logic [7:0] lead_mask(input logic [3:0] n);
      logic [7:0] m;
      m = 8'hff;
      unique case (n)
         4'd1: m = 8'h80;
         4'd2: m = 8'hc0;
         4'd3: m = 8'he0;
         4'd4: m = 8'hf0;
         4'd5: m = 8'hf8;
         4'd6: m = 8'hfc;
         4'd7: m = 8'hfe;
         default: m = 8'hff;
      endcase
      return m;
   endfunction

endpackage

// ----- src/bta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/bta_ctrl.sv -----
// Controller state machine for the bitmap tile assembler.
// Depends on bta_pkg; drives the datapath through dp_cmd_type.
module bta_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bta_pkg::dp_status_type st,
   output bta_pkg::dp_cmd_type    cmd
);
   import bta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ADDR, S_RD0, S_WR0, S_WR1, S_WRC, S_STEP, S_RDATA, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            if (st.cmd_code == CMD_DATA && st.tile_open) state_in = S_ADDR;
            else if (st.cmd_code == CMD_READ) state_in = S_RDATA;
            else state_in = S_IDLE;
         end
         S_ADDR: begin
            if (st.place_mono) state_in = S_RD0;
            else if (st.place_colour) state_in = S_WRC;
            else state_in = S_STEP;
         end
         S_RD0:   state_in = S_WR0;
         S_WR0:   state_in = S_WR1;
         S_WR1:   state_in = S_STEP;
         S_WRC:   state_in = S_STEP;
         S_STEP:  state_in = st.last_byte ? S_RESP : S_IDLE;
         S_RDATA: state_in = S_RESP;
         S_RESP:  if (!st.rsp_full) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign cmd.load     = req_valid && req_ready;
   assign cmd.decode   = (state_ff == S_DECODE);
   assign cmd.addr     = (state_ff == S_ADDR);
   assign cmd.rd0      = (state_ff == S_RD0);
   assign cmd.wr0      = (state_ff == S_WR0);
   assign cmd.wr1      = (state_ff == S_WR1);
   assign cmd.wrc      = (state_ff == S_WRC);
   assign cmd.step     = (state_ff == S_STEP);
   assign cmd.rdata    = (state_ff == S_RDATA);
   assign cmd.load_rsp = (state_ff == S_RESP) && !st.rsp_full;

   a_load_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.decode)
      else $error("accepted transaction not decoded");
   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.rd0 |=> cmd.wr0 ##1 cmd.wr1)
      else $error("mono read-modify-write sequence broken");
   a_resp_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && st.rsp_full) |=> state_ff == S_RESP)
      else $error("pending result dropped");
endmodule

// ----- src/bta_datapath.sv -----
// Datapath: config registers, tile state, placement arithmetic, store, result.
// Depends on bta_pkg and bta_ram; steered by bta_ctrl.
module bta_datapath #(
   parameter int MAX_WIDTH  = bta_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bta_pkg::MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_cmd,
   input  logic [7:0]             req_x_offset,
   input  logic [7:0]             req_y_offset,
   input  logic [8:0]             req_tile_width,
   input  logic [8:0]             req_tile_height,
   input  logic [7:0]             req_data_byte,
   input  logic [15:0]            req_read_addr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_read_data,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_wdata,
   input  bta_pkg::dp_cmd_type    cmd,
   output bta_pkg::dp_status_type st
);
   import bta_pkg::*;

   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(STORE_SIZE);

   logic [8:0] bitmap_width_ff, bitmap_height_ff;
   logic       pixel_mode_ff;

   logic [1:0]  cmd_ff;
   logic [7:0]  data_ff;
   logic [15:0] item_addr_ff;
   logic [7:0]  tile_x_ff, tile_y_ff;
   logic [8:0]  tile_w_ff, tile_h_ff;
   logic [8:0]  row_ff, col_ff;
   logic [COUNT_W-1:0] count_ff;

   logic        open_ff, place_mono_ff, place_col_ff;
   logic [9:0]  idx_ff;
   logic [15:0] m16_ff, d16_ff;
   logic [18:0] base_ff;
   logic [17:0] area_ff, target_ff;
   logic [AW-1:0] addr0_ff, addr1_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff, res_status_ff;
   logic [7:0]  rsp_data_ff, res_data_ff;

   logic [8:0]  eff_w, eff_h, rlen, srb;
   logic        open_d, col_ok, drow_ok, pok;
   logic [9:0]  drow, bi, p;
   logic [12:0] span, bitpos0, lim;
   logic [3:0]  n;
   logic [7:0]  nm;
   logic [15:0] clip16, m16, d16;

   logic [9:0]  col_inc;
   logic        wrap, last;
   logic [18:0] sum;
   logic [COUNT_W-1:0] sat;
   logic        complete;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // live effective geometry
   always_comb begin
      eff_w = bitmap_width_ff;
      if (bitmap_width_ff == '0) eff_w = 9'd1;
      else if (32'(bitmap_width_ff) > MAX_WIDTH) eff_w = 9'(MAX_WIDTH);
      eff_h = bitmap_height_ff;
      if (bitmap_height_ff == '0) eff_h = 9'd1;
      else if (32'(bitmap_height_ff) > MAX_HEIGHT) eff_h = 9'(MAX_HEIGHT);
      rlen = pixel_mode_ff ? eff_w : 9'((10'(eff_w) + 10'd7) >> 3);
      srb  = pixel_mode_ff ? tile_w_ff : 9'((10'(tile_w_ff) + 10'd7) >> 3);
   end

   // placement of the current source byte
   always_comb begin
      open_d  = (tile_w_ff != '0) && (tile_h_ff != '0) && (row_ff < tile_h_ff);
      drow    = 10'(tile_y_ff) + 10'(tile_h_ff) - 10'd1 - 10'(row_ff);
      drow_ok = drow < 10'(eff_h);
      col_ok  = col_ff < srb;
      bi      = 10'(tile_x_ff[7:3]) + 10'(col_ff);
      span    = 13'(tile_w_ff) - {1'b0, col_ff, 3'b000};
      n       = (span >= 13'd8) ? 4'd8 : span[3:0];
      nm      = lead_mask(n);
      bitpos0 = {bi, 3'b000};
      lim     = (13'(eff_w) > bitpos0) ? 13'(eff_w) - bitpos0 : 13'd0;
      clip16  = (lim >= 13'd16) ? 16'hffff : ~(16'hffff >> lim[3:0]);
      m16     = ({nm, 8'h00} >> tile_x_ff[2:0]) & clip16;
      d16     = {data_ff, 8'h00} >> tile_x_ff[2:0];
      p       = 10'(tile_x_ff) + 10'(col_ff);
      pok     = p < 10'(eff_w);
   end

   // advance through the tile and accumulate pixels
   always_comb begin
      col_inc  = 10'(col_ff) + 10'd1;
      wrap     = col_inc >= 10'(srb);
      last     = wrap && (10'(row_ff) + 10'd1 >= 10'(tile_h_ff));
      sum      = 19'(count_ff) + 19'(area_ff);
      sat      = (sum > 19'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
      complete = 32'(sat) == 32'(target_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_width_ff  <= 9'd256;
         bitmap_height_ff <= 9'd256;
         pixel_mode_ff    <= 1'b0;
         tile_x_ff <= '0;
         tile_y_ff <= '0;
         tile_w_ff <= '0;
         tile_h_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_BITMAP_WIDTH:  bitmap_width_ff  <= csr_wdata;
               CSR_BITMAP_HEIGHT: bitmap_height_ff <= csr_wdata;
               CSR_PIXEL_MODE:    pixel_mode_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.load && req_cmd == CMD_TILE) begin
            tile_x_ff <= req_x_offset;
            tile_y_ff <= req_y_offset;
            tile_w_ff <= req_tile_width;
            tile_h_ff <= req_tile_height;
            row_ff    <= '0;
            col_ff    <= '0;
         end
         if (cmd.step) begin
            if (wrap) begin
               col_ff <= '0;
               row_ff <= row_ff + 9'd1;
            end else begin
               col_ff <= col_inc[8:0];
            end
            if (last) begin
               count_ff <= complete ? '0 : sat;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff       <= req_cmd;
         data_ff      <= req_data_byte;
         item_addr_ff <= req_read_addr;
      end
      if (cmd.decode) begin
         open_ff       <= open_d;
         place_mono_ff <= open_d && drow_ok && col_ok && !pixel_mode_ff && (m16 != '0);
         place_col_ff  <= open_d && drow_ok && col_ok && pixel_mode_ff && pok;
         idx_ff        <= pixel_mode_ff ? p : bi;
         m16_ff        <= m16;
         d16_ff        <= d16;
         base_ff       <= 19'(drow * rlen);
         area_ff       <= 18'(tile_w_ff * tile_h_ff);
         target_ff     <= 18'(eff_w * eff_h);
      end
      if (cmd.addr) begin
         addr0_ff <= AW'(20'(base_ff) + 20'(idx_ff));
         addr1_ff <= AW'(20'(base_ff) + 20'(idx_ff) + 20'd1);
      end
      if (cmd.step && last) begin
         res_status_ff <= complete ? ST_COMPLETE : ST_TILE_DONE;
         res_data_ff   <= '0;
      end
      if (cmd.rdata) begin
         res_status_ff <= ST_READ;
         res_data_ff   <= (32'(item_addr_ff) < STORE_SIZE) ? ram_rdata : 8'h00;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   // store port steering: merge masked bits into the byte just read
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr0_ff;
      ram_wdata = data_ff;
      ram_raddr = addr0_ff;
      if (cmd.decode) ram_raddr = AW'(item_addr_ff);
      if (cmd.wr0) begin
         ram_raddr = addr1_ff;
         ram_we    = m16_ff[15:8] != '0;
         ram_wdata = (ram_rdata & ~m16_ff[15:8]) | (d16_ff[15:8] & m16_ff[15:8]);
      end
      if (cmd.wr1) begin
         ram_waddr = addr1_ff;
         ram_we    = m16_ff[7:0] != '0;
         ram_wdata = (ram_rdata & ~m16_ff[7:0]) | (d16_ff[7:0] & m16_ff[7:0]);
      end
      if (cmd.wrc) ram_we = 1'b1;
   end

   bta_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign st.cmd_code     = cmd_ff;
   assign st.tile_open    = open_d;
   assign st.place_mono   = place_mono_ff;
   assign st.place_colour = place_col_ff;
   assign st.last_byte    = last;
   assign st.rsp_full     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && last && complete) |=> count_ff == '0)
      else $error("pixel count not cleared on completion");
   a_step_open: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> open_ff)
      else $error("tile advanced with no open tile");
endmodule

// ----- src/bitmap_tile_assembler.sv -----
// Top level of the bitmap tile assembler: controller, datapath and byte store.
// Depends on bta_pkg, bta_ctrl, bta_datapath (which holds bta_ram).
//
//   channel   direction  handshake                payload
//   req_*     in         req_valid / req_ready    cmd, offsets, tile size, data, read addr
//   rsp_*     out        rsp_valid / rsp_ready    status, read_data
//   csr_*     in         csr_write_en             csr_index, csr_wdata
//
// Steps per item: tile start, unknown command and data with no open tile: decode only;
// read: decode, read, result; data byte: decode, address, then a colour write, a drop
// or two read-modify-writes (mono), then step; the tile's last byte adds a result.
// Reset clears control state, tile state and the pixel count; the store is not cleared.
// A result waits in the output register; the next item is taken meanwhile and the
// block stalls only when a second result is ready before the first is taken.
module bitmap_tile_assembler #(
   parameter int MAX_WIDTH  = bta_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bta_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_x_offset,
   input  logic [7:0]  req_y_offset,
   input  logic [8:0]  req_tile_width,
   input  logic [8:0]  req_tile_height,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_read_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import bta_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   bta_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_x_offset    (req_x_offset),
      .req_y_offset    (req_y_offset),
      .req_tile_width  (req_tile_width),
      .req_tile_height (req_tile_height),
      .req_data_byte   (req_data_byte),
      .req_read_addr   (req_read_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .st              (st)
   );
endmodule
